[rtl/core/cpr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types, codes and channel widening functions for the camera pixel
// to RGBA unit.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int DIM_W    = 12;
  localparam int COUNT_W  = 24;
  localparam int PIX_W    = 2 * DIM_W;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int MAX_DIM  = 2048;

  localparam logic [COUNT_W-1:0] COUNT_CAP = {COUNT_W{1'b1}};

  // pixel format codes
  localparam logic [1:0] FMT_RGB565 = 2'd0;
  localparam logic [1:0] FMT_YUV422 = 2'd1;
  localparam logic [1:0] FMT_UNSUP  = 2'd2;
  localparam logic [1:0] FMT_GRAY   = 2'd3;

  // frame status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_BAD_DIM = 2'd2;
  localparam logic [1:0] ST_BAD_FMT = 2'd3;

  // register indexes
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [1:0] FMT_RESET = FMT_GRAY;
  localparam logic [7:0] ALPHA_FULL = 8'hFF;

  typedef struct packed {
    logic [1:0]       fmt;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  // x*255/31 truncated, as 8x + floor(7x/31)
  function automatic logic [7:0] widen5(input logic [4:0] x);
    logic [7:0] p7;
    logic [2:0] k;
    p7 = 8'(x) * 8'd7;
    k  = 3'd0;
    for (int j = 1; j <= 7; j++) begin
      if (p7 >= 8'(31 * j)) k = k + 3'd1;
    end
    return {x, 3'b000} + 8'(k);
  endfunction

  // x*255/63 truncated, as 4x + floor(x/21)
  function automatic logic [7:0] widen6(input logic [5:0] x);
    logic [1:0] k;
    k = 2'd0;
    for (int j = 1; j <= 3; j++) begin
      if (x >= 6'(21 * j)) k = k + 2'd1;
    end
    return {x, 2'b00} + 8'(k);
  endfunction

endpackage
`default_nettype wire

[rtl/core/cpr_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_regs
// APB-style register file holding pixel format and frame dimensions.
// ----------------------------------------------------------------------------
module cpr_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cpr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [cpr_pkg::DATA_W-1:0]  pwdata,
  output logic      [cpr_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output cpr_pkg::cfg_t                    cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt    <= cpr_pkg::FMT_RESET;
      cfg.width  <= '0;
      cfg.height <= '0;
    end else if (wr_en) begin
      case (idx)
        cpr_pkg::REG_FORMAT: cfg.fmt    <= pwdata[1:0];
        cpr_pkg::REG_WIDTH:  cfg.width  <= pwdata[cpr_pkg::DIM_W-1:0];
        cpr_pkg::REG_HEIGHT: cfg.height <= pwdata[cpr_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cpr_pkg::REG_FORMAT: prdata = {30'd0, cfg.fmt};
      cpr_pkg::REG_WIDTH:  prdata = {20'd0, cfg.width};
      cpr_pkg::REG_HEIGHT: prdata = {20'd0, cfg.height};
      default:             prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/cpr_convert.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_convert
// Frame byte counter, RGB565 low byte hold, pixel conversion, frame status
// and the result register.
// ----------------------------------------------------------------------------
module cpr_convert (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cpr_pkg::cfg_t cfg,
  input  wire logic          src_valid,
  input  wire logic [7:0]    src_byte,
  input  wire logic          src_last,
  output logic               take,
  output logic               result_valid,
  input  wire logic          result_stall,
  output logic               pixel_valid,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic               frame_done,
  output logic [1:0]         frame_status
);

  logic [cpr_pkg::COUNT_W-1:0] frame_bytes;
  logic [7:0]                  held_low_byte;

  logic                        dims_ok;
  logic [cpr_pkg::PIX_W-1:0]   pix_raw;
  logic [cpr_pkg::PIX_W-1:0]   pixels;
  logic                        cnt_live;
  logic                        in_frame_gray;
  logic                        in_frame_pair;
  logic [cpr_pkg::COUNT_W-1:0] count_inc;
  logic [cpr_pkg::PIX_W:0]     need;
  logic [15:0]                 packed565;
  logic                        pix_v;
  logic [7:0]                  r_c, g_c, b_c;
  logic                        hold_en;
  logic [1:0]                  status_c;

  assign take = src_valid && (!result_valid || !result_stall);

  assign dims_ok = (cfg.width != '0) && (cfg.height != '0) &&
                   ({1'b0, cfg.width}  <= 13'(cpr_pkg::MAX_DIM)) &&
                   ({1'b0, cfg.height} <= 13'(cpr_pkg::MAX_DIM));
  assign pix_raw = cpr_pkg::PIX_W'(cfg.width) * cpr_pkg::PIX_W'(cfg.height);
  assign pixels  = dims_ok ? pix_raw : '0;

  assign cnt_live      = frame_bytes != cpr_pkg::COUNT_CAP;
  assign in_frame_gray = frame_bytes < pixels;
  assign in_frame_pair = {1'b0, frame_bytes[cpr_pkg::COUNT_W-1:1]} < pixels;
  assign count_inc     = cnt_live ? frame_bytes + 1'b1 : frame_bytes;
  assign need          = (cfg.fmt == cpr_pkg::FMT_GRAY) ? {1'b0, pixels}
                                                        : {pixels, 1'b0};
  assign packed565     = {src_byte, held_low_byte};

  always_comb begin
    pix_v   = 1'b0;
    r_c     = '0;
    g_c     = '0;
    b_c     = '0;
    hold_en = 1'b0;
    if (dims_ok && cnt_live) begin
      case (cfg.fmt)
        cpr_pkg::FMT_GRAY: begin
          if (in_frame_gray) begin
            pix_v = 1'b1;
            r_c   = src_byte;
            g_c   = src_byte;
            b_c   = src_byte;
          end
        end
        cpr_pkg::FMT_RGB565: begin
          if (!frame_bytes[0]) begin
            hold_en = 1'b1;
          end else if (in_frame_pair) begin
            pix_v = 1'b1;
            r_c   = cpr_pkg::widen5(packed565[15:11]);
            g_c   = cpr_pkg::widen6(packed565[10:5]);
            b_c   = cpr_pkg::widen5(packed565[4:0]);
          end
        end
        cpr_pkg::FMT_YUV422: begin
          if (!frame_bytes[0] && in_frame_pair) begin
            pix_v = 1'b1;
            r_c   = src_byte;
            g_c   = src_byte;
            b_c   = src_byte;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (!dims_ok) begin
      status_c = cpr_pkg::ST_BAD_DIM;
    end else if (cfg.fmt == cpr_pkg::FMT_UNSUP) begin
      status_c = cpr_pkg::ST_BAD_FMT;
    end else if ({1'b0, count_inc} < need) begin
      status_c = cpr_pkg::ST_SHORT;
    end else begin
      status_c = cpr_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid  <= 1'b0;
      frame_bytes   <= '0;
      held_low_byte <= '0;
    end else begin
      if (take) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (take) begin
        if (src_last) begin
          frame_bytes   <= '0;
          held_low_byte <= '0;
        end else begin
          frame_bytes <= count_inc;
          if (hold_en) held_low_byte <= src_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pixel_valid  <= pix_v;
      red          <= r_c;
      green        <= g_c;
      blue         <= b_c;
      frame_done   <= src_last;
      frame_status <= src_last ? status_c : cpr_pkg::ST_OK;
    end
  end

  // status only accompanies the final byte of a frame
  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && !frame_done |-> frame_status == cpr_pkg::ST_OK)
    else $error("frame status set without frame done");

  // channels are blank when no pixel is carried
  a_blank_no_pixel: assert property (@(posedge clk) disable iff (rst)
    result_valid && !pixel_valid |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
    else $error("channel data without pixel");

  // the frame counter restarts after the final byte
  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    take && src_last |=> frame_bytes == '0 && held_low_byte == 8'd0)
    else $error("byte count not cleared at frame end");

  // the counter moves by one step per byte at most
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    take && !src_last && cnt_live |=> frame_bytes == $past(frame_bytes) + 1'b1)
    else $error("byte count step wrong");

  // a result is not replaced while the consumer stalls it
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(frame_done))
    else $error("stalled result lost");

endmodule
`default_nettype wire

[rtl/core/camera_pixel_to_rgba_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// camera_pixel_to_rgba_unit
// Converts a camera frame payload, one byte per request, into RGBA pixels.
//
// Every accepted byte gives exactly one result request, so the unit sustains
// one byte per clock while the output is not stalled. A byte passes an input
// register and then the result register. The loop that sets the rate is the
// frame byte counter and the held RGB565 low byte, updated as each byte moves
// into the result register. Grayscale copies the byte to red, green and blue;
// RGB565 joins two bytes low first and widens each channel to 8 bits; YUV422
// shows the luma bytes only. Alpha is always full. The result for the byte
// marked last carries frame done and the frame status; pixels from a frame
// whose status is not ok are to be discarded.
// Registers: pixel format at 0x0, frame width at 0x4, frame height at 0x8;
// the user is to write them only while the unit holds no request, which the
// unit itself does not enforce.
// ----------------------------------------------------------------------------
module camera_pixel_to_rgba_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cpr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [cpr_pkg::DATA_W-1:0]  pwdata,
  output logic      [cpr_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        byte_valid,
  output logic                             byte_stall,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        byte_last,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic                             pixel_valid,
  output logic [7:0]                       red,
  output logic [7:0]                       green,
  output logic [7:0]                       blue,
  output logic [7:0]                       alpha,
  output logic                             frame_done,
  output logic [1:0]                       frame_status
);

  cpr_pkg::cfg_t cfg;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       take;
  logic       accept;

  assign byte_stall = in_valid && !take;
  assign accept     = byte_valid && !byte_stall;
  assign alpha      = cpr_pkg::ALPHA_FULL;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= data_byte;
      in_last <= byte_last;
    end
  end

  cpr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpr_convert u_convert (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .src_valid    (in_valid),
    .src_byte     (in_byte),
    .src_last     (in_last),
    .take         (take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pixel_valid  (pixel_valid),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .frame_done   (frame_done),
    .frame_status (frame_status)
  );

endmodule
`default_nettype wire
